// ===== hw/rtl/crc_gc_pkg.sv =====
// Shared types and constants for the CRC generate/check unit.
package crc_gc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_W    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE = 2'd2;

  localparam int CFG_DATA_W  = 32;
  localparam int GEN_W       = 32;
  localparam int WIDTH_REG_W = 6;

  localparam logic [GEN_W-1:0] GEN_RESET     = 32'd7;
  localparam int               CHECK_W_RESET = 8;

  // Per-cycle control broadcast to every remainder cell
  typedef struct packed {
    logic advance;  // shift the chain this cycle
    logic fb;       // feedback bit, XORed in where the generator has a tap
    logic clear;    // zero the remainder (end of a checked codeword)
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/crc_gc_cell.sv =====
// One remainder bit of the CRC division chain.
module crc_gc_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  crc_gc_pkg::cell_ctrl_t ctrl,
  input  logic                   shift_in,
  input  logic                   gen_bit,
  input  logic                   active,
  output logic                   bit_q,
  output logic                   div_bit
);

  logic bit_r, bit_nxt;

  // div_bit is the division step result; the clear only acts on the register
  always_comb begin
    div_bit = bit_r;
    if (ctrl.advance) begin
      // lanes above the current width stay zero
      div_bit = active & (shift_in ^ (ctrl.fb & gen_bit));
    end
    bit_nxt = ctrl.clear ? 1'b0 : div_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= 1'b0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  assign bit_q = bit_r;

endmodule

// ===== hw/rtl/crc_generate_and_check_unit.sv =====
// Top level of the bit-serial CRC generate/check unit.
//
// Bit-serial CRC with a programmable generator (implied leading one, low
// coefficients in register 0, degree W in register 1, clamped to
// 1..MAX_CHECK_WIDTH). Each input beat carries one bit, first bit first.
// Generate mode (register 2 = 0): every bit is echoed, and after the bit
// marked last the W FCS bits follow MSB first, the final one flagged
// end_of_run. Check mode (register 2 = 1): every codeword bit is echoed;
// the beat for the last bit carries end_of_run and crc_error (nonzero
// remainder). Rate: one input bit per cycle, back to back while the output
// does not stall and no FCS is being sent; a row of one-bit remainder cells
// shifts once per accepted bit. In generate mode the last bit is followed by
// W FCS beats, one per cycle while out_stall is low, and in_stall is held
// until the final FCS beat is loaded. The first bit of the next message
// can be taken at the edge right after the final FCS beat is loaded, the
// same edge at which that beat leaves. Check mode sends no FCS and adds no
// stall of its own. Results go through a single output register; input is
// taken when that register is empty or its beat leaves in the same cycle.
// The remainder clears after every message. Write configuration only
// while idle.
module crc_generate_and_check_unit #(
  parameter int MAX_CHECK_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_data_bit,
  input  logic                               in_last_bit,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_bit,
  output logic                               out_is_fcs,
  output logic                               out_end_of_run,
  output logic                               out_crc_error,
  // configuration
  input  logic                               cfg_we,
  input  logic [crc_gc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_gc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int WW = $clog2(MAX_CHECK_WIDTH + 1);
  localparam int RESET_W = (crc_gc_pkg::CHECK_W_RESET > MAX_CHECK_WIDTH) ?
                           MAX_CHECK_WIDTH : crc_gc_pkg::CHECK_W_RESET;

  // ---- configuration registers ----
  logic [crc_gc_pkg::GEN_W-1:0] gen_r, gen_nxt;
  logic [WW-1:0]                width_r, width_nxt;  // effective width
  logic                         mode_r, mode_nxt;
  logic [crc_gc_pkg::WIDTH_REG_W-1:0] wr_width;

  assign wr_width = cfg_wdata[crc_gc_pkg::WIDTH_REG_W-1:0];

  always_comb begin
    gen_nxt   = gen_r;
    width_nxt = width_r;
    mode_nxt  = mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        crc_gc_pkg::REG_GEN_LOW: begin
          gen_nxt = cfg_wdata[crc_gc_pkg::GEN_W-1:0];
        end
        crc_gc_pkg::REG_CHECK_W: begin
          // zero acts as one, oversize clamps to the cell count
          if (wr_width == '0) begin
            width_nxt = WW'(1);
          end else if (int'(wr_width) > MAX_CHECK_WIDTH) begin
            width_nxt = WW'(MAX_CHECK_WIDTH);
          end else begin
            width_nxt = WW'(wr_width);
          end
        end
        crc_gc_pkg::REG_CHECK_MODE: begin
          mode_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---- handshake and drain control ----
  logic          out_valid_r, out_valid_nxt;
  logic          out_bit_r, out_bit_nxt;
  logic          out_fcs_r, out_fcs_nxt;
  logic          out_end_r, out_end_nxt;
  logic          out_err_r, out_err_nxt;
  logic [WW-1:0] drain_cnt_r, drain_cnt_nxt;   // FCS beats still to send

  logic slot_free, draining, in_acc, drain_step;

  assign slot_free  = !out_valid_r || !out_stall;
  assign draining   = (drain_cnt_r != '0);
  assign in_stall   = draining || !slot_free;
  assign in_acc     = in_valid && !in_stall;
  assign drain_step = draining && slot_free;

  // ---- remainder cell chain ----
  logic [MAX_CHECK_WIDTH-1:0] rem_q, rem_div, active, top_sel;
  logic [MAX_CHECK_WIDTH:0]   active_ext;
  logic                       top_bit, lead_in;
  crc_gc_pkg::cell_ctrl_t     ctrl;

  // lane i is live when i < width; the top lane is the last live one
  always_comb begin
    for (int i = 0; i < MAX_CHECK_WIDTH; i++) begin
      active[i] = (i < int'(width_r));
    end
  end
  assign active_ext = {1'b0, active};
  assign top_sel    = active & ~active_ext[MAX_CHECK_WIDTH:1];
  assign top_bit    = |(rem_q & top_sel);

  always_comb begin
    ctrl.advance = in_acc || drain_step;
    ctrl.clear   = in_acc && in_last_bit && mode_r;
    if (drain_step) begin
      ctrl.fb = 1'b0;                      // plain shift while sending FCS
      lead_in = 1'b0;
    end else if (mode_r) begin
      ctrl.fb = top_bit;                   // check: divide the codeword
      lead_in = in_data_bit;
    end else begin
      ctrl.fb = top_bit ^ in_data_bit;     // generate: augmented division
      lead_in = 1'b0;
    end
  end

  for (genvar i = 0; i < MAX_CHECK_WIDTH; i++) begin : g_cell
    logic shift_in, gen_bit;
    if (i == 0) begin : g_lead
      assign shift_in = lead_in;
    end else begin : g_link
      assign shift_in = rem_q[i-1];
    end
    if (i < crc_gc_pkg::GEN_W) begin : g_tap
      assign gen_bit = gen_r[i];
    end else begin : g_notap
      assign gen_bit = 1'b0;
    end

    crc_gc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .shift_in (shift_in),
      .gen_bit  (gen_bit),
      .active   (active[i]),
      .bit_q    (rem_q[i]),
      .div_bit  (rem_div[i])
    );
  end

  // ---- output register ----
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    out_fcs_nxt   = out_fcs_r;
    out_end_nxt   = out_end_r;
    out_err_nxt   = out_err_r;
    drain_cnt_nxt = drain_cnt_r;
    if (slot_free) begin
      out_valid_nxt = in_acc || drain_step;
    end
    if (in_acc) begin
      out_bit_nxt = in_data_bit;
      out_fcs_nxt = 1'b0;
      out_end_nxt = mode_r && in_last_bit;
      // rem_div is the remainder before the clear takes effect
      out_err_nxt = mode_r && in_last_bit && (|(rem_div & active));
      if (in_last_bit && !mode_r) begin
        drain_cnt_nxt = width_r;
      end
    end else if (drain_step) begin
      out_bit_nxt   = top_bit;
      out_fcs_nxt   = 1'b1;
      out_end_nxt   = (drain_cnt_r == WW'(1));
      out_err_nxt   = 1'b0;
      drain_cnt_nxt = drain_cnt_r - WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= crc_gc_pkg::GEN_RESET;
      width_r     <= WW'(RESET_W);
      mode_r      <= 1'b0;
      out_valid_r <= 1'b0;
      drain_cnt_r <= '0;
    end else begin
      gen_r       <= gen_nxt;
      width_r     <= width_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
    out_fcs_r <= out_fcs_nxt;
    out_end_r <= out_end_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bit        = out_bit_r;
  assign out_is_fcs     = out_fcs_r;
  assign out_end_of_run = out_end_r;
  assign out_crc_error  = out_err_r;

endmodule

// ===== tb/crc_generate_and_check_unit_tb.sv =====
// Self-checking testbench for the bit-serial CRC generate/check unit.
module crc_generate_and_check_unit_tb;

  localparam int   MAX_W         = 32;
  localparam int   IDLE_PCT      = 9;
  localparam int   RANDOM_BITS   = 190;
  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_CHECK    = 1'b1;

  typedef struct packed {
    logic data_bit;
    logic last_bit;
  } bit_beat_t;

  typedef struct packed {
    logic out_bit;
    logic is_fcs;
    logic end_of_run;
    logic crc_error;
  } crc_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic                              in_data_bit;
  logic                              in_last_bit;
  logic                              out_valid;
  logic                              out_stall;
  logic                              out_bit;
  logic                              out_is_fcs;
  logic                              out_end_of_run;
  logic                              out_crc_error;
  logic                              cfg_we;
  logic [crc_gc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [crc_gc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  crc_generate_and_check_unit #(
    .MAX_CHECK_WIDTH(MAX_W)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_bit   (in_data_bit),
    .in_last_bit   (in_last_bit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bit       (out_bit),
    .out_is_fcs    (out_is_fcs),
    .out_end_of_run(out_end_of_run),
    .out_crc_error (out_crc_error),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Shadow copy of the programmed registers and the running remainder.
  logic [crc_gc_pkg::GEN_W-1:0]       gen_low_q;
  logic [crc_gc_pkg::WIDTH_REG_W-1:0] chk_w_q;
  logic                               mode_q;
  logic [MAX_W-1:0]                   crc_rem_q;

  bit_beat_t   pending_bits[$];    // beats still to be offered on the input
  crc_result_t expected_beats[$];  // result beats the unit owes us, oldest first
  logic        frame_bits[$];      // scratch: message or codeword under construction

  int fail_cnt;
  int bits_sent;
  int results_seen;
  int gen_msgs;
  int chk_words;
  int errs_flagged;
  bit quiet;         // no idling on either side while set
  bit in_beat_done;  // current input beat was taken at the last rising edge

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous cap: far above the slowest legal run (every message at W = 32
  // with the output stalled at the random rate).
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // Out-of-range width register values clamp to 1..MAX_W.
  function automatic int eff_width(logic [crc_gc_pkg::WIDTH_REG_W-1:0] cw);
    if (cw == 0) return 1;
    if (cw > MAX_W) return MAX_W;
    return int'(cw);
  endfunction

  // One division step. Generate mode feeds the bit in at the top
  // (augmented division); check mode shifts it in at the bottom.
  function automatic logic [MAX_W-1:0] crc_next(logic [MAX_W-1:0] rem, logic d, logic chk,
                                               logic [crc_gc_pkg::GEN_W-1:0] gen, int w);
    logic [MAX_W-1:0] mask;
    logic             top;
    mask = (w >= MAX_W) ? '1 : (MAX_W'(1) << w) - 1'b1;
    rem  = rem & mask;
    gen  = gen & mask;
    top  = rem[w-1];
    if (chk == MODE_CHECK) begin
      rem = ((rem << 1) | MAX_W'(d)) & mask;
      if (top) rem = rem ^ gen;
    end else begin
      rem = (rem << 1) & mask;
      if (top ^ d) rem = rem ^ gen;
    end
    return rem;
  endfunction

  // Expected result beats for one accepted input bit.
  function automatic void crc_predict_bit(logic d, logic last);
    int               w;
    logic [MAX_W-1:0] r;
    crc_result_t      res;
    w   = eff_width(chk_w_q);
    r   = crc_next(crc_rem_q, d, mode_q, gen_low_q, w);
    res = '0;
    res.out_bit = d;
    if (mode_q == MODE_CHECK) begin
      res.end_of_run = last;
      res.crc_error  = last && (r != '0);
      expected_beats.push_back(res);
    end else begin
      expected_beats.push_back(res);
      // FCS follows the last bit, MSB first
      if (last) begin
        for (int i = 0; i < w; i++) begin
          res.out_bit    = r[w-1-i];
          res.is_fcs     = 1'b1;
          res.end_of_run = (i == w - 1);
          expected_beats.push_back(res);
        end
      end
    end
    crc_rem_q = last ? '0 : r;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_cnt++;
  endtask

  // Configuration writes happen only with nothing in flight.
  task automatic cfg_write(logic [crc_gc_pkg::CFG_IDX_W-1:0] idx,
                           logic [crc_gc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      crc_gc_pkg::REG_GEN_LOW:    gen_low_q = val;
      crc_gc_pkg::REG_CHECK_W:    chk_w_q   = val[crc_gc_pkg::WIDTH_REG_W-1:0];
      crc_gc_pkg::REG_CHECK_MODE: mode_q    = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Junk in the unused upper bits must be ignored by the unit.
  task automatic configure(logic [crc_gc_pkg::GEN_W-1:0] gen, int w, logic mode);
    cfg_write(crc_gc_pkg::REG_GEN_LOW, gen);
    cfg_write(crc_gc_pkg::REG_CHECK_W, ($urandom() & ~32'h3F) | (w & 32'h3F));
    cfg_write(crc_gc_pkg::REG_CHECK_MODE, ($urandom() & ~32'h1) | mode);
  endtask

  // Sender holds off until every expected beat has arrived, then lets the
  // FCS tail and the output register settle.
  task automatic wait_idle();
    while (pending_bits.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (MAX_W + 4) @(posedge clk);
  endtask

  task automatic push_frame(bit mark_last);
    bit_beat_t b;
    foreach (frame_bits[i]) begin
      b.data_bit = frame_bits[i];
      b.last_bit = mark_last && (i == frame_bits.size() - 1);
      pending_bits.push_back(b);
    end
    bits_sent += frame_bits.size();
    frame_bits.delete();
  endtask

  task automatic random_frame(int n);
    frame_bits.delete();
    repeat (n) frame_bits.push_back(1'($urandom_range(1)));
  endtask

  task automatic send_word(logic [63:0] v, int n, bit mark_last);
    frame_bits.delete();
    for (int i = n - 1; i >= 0; i--) frame_bits.push_back(v[i]);
    push_frame(mark_last);
  endtask

  // Append the FCS the current generator gives for frame_bits, turning the
  // message into a codeword that checks clean.
  task automatic append_fcs();
    int               w;
    logic [MAX_W-1:0] r;
    w = eff_width(chk_w_q);
    r = '0;
    foreach (frame_bits[i]) r = crc_next(r, frame_bits[i], MODE_GENERATE, gen_low_q, w);
    for (int i = w - 1; i >= 0; i--) frame_bits.push_back(r[i]);
  endtask

  // Driver: new beat on the falling edge once the previous one was taken.
  // Payload stays put while the unit stalls.
  always @(negedge clk) begin
    bit_beat_t nb;
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_data_bit <= 1'b0;
      in_last_bit <= 1'b0;
    end else if (!in_valid || in_beat_done) begin
      if (pending_bits.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        nb = pending_bits.pop_front();
        in_valid    <= 1'b1;
        in_data_bit <= nb.data_bit;
        in_last_bit <= nb.last_bit;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: score output beats, then predict from the input beat taken
  // at this same edge (its results can only show up later).
  always @(posedge clk) begin
    crc_result_t want;
    crc_result_t got;
    in_beat_done = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        got = {out_bit, out_is_fcs, out_end_of_run, out_crc_error};
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected (bit/fcs/end/err %b)",
                                    results_seen, got));
        end else begin
          want = expected_beats.pop_front();
          if (got !== want)
            report_mismatch($sformatf("result beat %0d: bit/fcs/end/err %b, expected %b",
                                      results_seen, got, want));
          if (want.end_of_run) begin
            if (want.is_fcs) gen_msgs++;
            else chk_words++;
            if (want.crc_error) errs_flagged++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        crc_predict_bit(in_data_bit, in_last_bit);
        in_beat_done = 1'b1;
      end
    end
  end

  initial begin
    int target;
    int n;
    int k;
    int w;
    logic [crc_gc_pkg::GEN_W-1:0] g;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = crc_gc_pkg::REG_GEN_LOW;
    cfg_wdata    = '0;
    quiet        = 1'b0;
    fail_cnt     = 0;
    bits_sent    = 0;
    results_seen = 0;
    gen_msgs     = 0;
    chk_words    = 0;
    errs_flagged = 0;
    gen_low_q    = crc_gc_pkg::GEN_RESET;
    chk_w_q      = crc_gc_pkg::WIDTH_REG_W'(crc_gc_pkg::CHECK_W_RESET);
    mode_q       = MODE_GENERATE;
    crc_rem_q    = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // Reset defaults (x^8 + x^2 + x + 1, generate): one-bit messages of
    // both values, then a short one.
    send_word(1, 1, 1);
    send_word(0, 1, 1);
    send_word(4'b1011, 4, 1);
    wait_idle();

    // Width changed mid-message: remainder kept, masked to four bits.
    send_word(2'b10, 2, 0);
    wait_idle();
    cfg_write(crc_gc_pkg::REG_CHECK_W, 4);
    send_word(1, 1, 1);
    wait_idle();

    // Width 0 behaves as 1 (parity generator).
    configure(1, 0, MODE_GENERATE);
    send_word(3'b110, 3, 1);
    wait_idle();

    // Width 63 clamps to 32, all generator taps set.
    configure('1, 63, MODE_GENERATE);
    send_word(1, 1, 1);
    wait_idle();

    // Check mode: clean codeword, corrupted codeword.
    configure(3, 4, MODE_CHECK);
    random_frame(2);
    append_fcs();
    push_frame(1);
    random_frame(2);
    append_fcs();
    k = $urandom_range(frame_bits.size() - 1);
    frame_bits[k] = ~frame_bits[k];
    push_frame(1);
    wait_idle();

    // Codeword shorter than W: it is its own remainder.
    configure(crc_gc_pkg::GEN_RESET, 8, MODE_CHECK);
    send_word(2'b01, 2, 1);
    wait_idle();

    // ---- random part ----
    target = bits_sent + RANDOM_BITS;
    for (int round = 0; bits_sent < target; round++) begin
      quiet = (round >= 5 && round < 10);  // long stretch with no idling
      if (round % 3 == 0) begin
        case ($urandom_range(9))
          0:       w = 0;
          1:       w = MAX_W;
          2:       w = $urandom_range(63, MAX_W + 1);
          default: w = $urandom_range(12, 1);
        endcase
        case ($urandom_range(7))
          0:       g = '0;
          1:       g = '1;
          default: g = $urandom();
        endcase
        configure(g, w, 1'($urandom_range(1)));
      end
      repeat ($urandom_range(4, 1)) begin
        if (mode_q == MODE_GENERATE) begin
          random_frame($urandom_range(10, 1));
        end else begin
          case ($urandom_range(9))
            0, 1: random_frame($urandom_range(10, 1));  // arbitrary bits
            2: begin                                    // damaged codeword
              random_frame($urandom_range(6, 1));
              append_fcs();
              k = $urandom_range(frame_bits.size() - 1);
              frame_bits[k] = ~frame_bits[k];
            end
            default: begin                              // clean codeword
              n = $urandom_range(6, 1);
              random_frame(n);
              append_fcs();
            end
          endcase
        end
        push_frame(1);
      end
      wait_idle();
    end

    quiet = 1'b0;
    wait_idle();

    $display("Run covered %0d input bits and %0d result beats: %0d generated messages,",
             bits_sent, results_seen, gen_msgs);
    $display("%0d checked codewords (%0d flagged bad), widths from clamp floor to ceiling.",
             chk_words, errs_flagged);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
